>>> rtl/slafl_pkg.sv
// ----------------------------------------------------------------------------
// slafl_pkg
// Shared constants, codes and types of the slot allocator.
// ----------------------------------------------------------------------------
package slafl_pkg;

    localparam int SLOTS  = 1024;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam int SLOT_W = 10;
    localparam int LIVE_W = 11;
    localparam int FUNC_W = 2;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    localparam logic [LIVE_W-1:0] LIVE_MAX = '1;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_POP
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
        logic              want;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              done;
        logic [LIVE_W-1:0] live;
    } res_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
    } flag_port_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] wdata;
    } stack_port_t;

endpackage

>>> rtl/slafl_ram.sv
// ----------------------------------------------------------------------------
// slafl_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module slafl_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/slafl_ctrl.sv
// ----------------------------------------------------------------------------
// slafl_ctrl
// Sequencer: reads flag and stack memories, decides, writes back, and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module slafl_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  slafl_pkg::req_t             in_req,
    output logic                        out_valid,
    input  logic                        out_ready,
    output slafl_pkg::res_t             out_res,
    output slafl_pkg::flag_port_t       flag_port,
    input  logic                        flag_rdata,
    output slafl_pkg::stack_port_t      stack_port,
    input  logic [slafl_pkg::ADDR_W-1:0] stack_rdata
);

    import slafl_pkg::*;

    state_t            state_reg, state_next;
    req_t              req_reg;
    logic [ADDR_W-1:0] got_reg, got_next;
    logic [CNT_W-1:0]  depth_reg, depth_next;
    logic [CNT_W-1:0]  fresh_reg, fresh_next;
    logic [LIVE_W-1:0] live_reg, live_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg;

    logic              accept;
    logic              out_free;
    logic              is_pop;
    logic              in_range;
    logic              commit;
    logic [ADDR_W-1:0] slot_addr;
    logic [LIVE_W-1:0] live_up, live_dn;
    res_t              res;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign is_pop    = (req_reg.func == FUNC_ALLOC) && (depth_reg != '0);
    assign slot_addr = ADDR_W'(req_reg.slot);
    assign in_range  = (32'(req_reg.slot) < 32'(fresh_reg)) && (32'(req_reg.slot) < SLOTS);
    assign live_up   = (live_reg != LIVE_MAX) ? LIVE_W'(live_reg + 1'b1) : live_reg;
    assign live_dn   = (live_reg != '0) ? LIVE_W'(live_reg - 1'b1) : live_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (is_pop)
                begin
                    state_next = ST_POP;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        flag_port        = '0;
        flag_port.re     = accept;
        flag_port.raddr  = ADDR_W'(in_req.slot);
        stack_port       = '0;
        stack_port.re    = accept;
        stack_port.raddr = ADDR_W'(depth_reg - 1'b1);
        commit           = 1'b0;
        res.slot         = req_reg.slot;
        res.done         = 1'b0;
        got_next         = got_reg;
        depth_next       = depth_reg;
        fresh_next       = fresh_reg;
        live_next        = live_reg;

        unique case (state_reg)
            ST_LOOK:
            begin
                if (is_pop)
                begin
                    got_next        = stack_rdata;
                    flag_port.re    = 1'b1;
                    flag_port.raddr = stack_rdata;
                end
                else if (out_free)
                begin
                    commit = 1'b1;
                    if (req_reg.func == FUNC_ALLOC)
                    begin
                        if (32'(fresh_reg) < SLOTS)
                        begin
                            flag_port.we    = 1'b1;
                            flag_port.waddr = ADDR_W'(fresh_reg);
                            flag_port.wdata = 1'b1;
                            fresh_next      = CNT_W'(fresh_reg + 1'b1);
                            live_next       = live_up;
                            res.slot        = SLOT_W'(fresh_reg);
                            res.done        = 1'b1;
                        end
                        else
                        begin
                            res.slot = '0;
                        end
                    end
                    else if (req_reg.func == FUNC_FREE)
                    begin
                        if (in_range && flag_rdata && (32'(depth_reg) < SLOTS))
                        begin
                            flag_port.we     = 1'b1;
                            flag_port.waddr  = slot_addr;
                            flag_port.wdata  = 1'b0;
                            stack_port.we    = 1'b1;
                            stack_port.waddr = ADDR_W'(depth_reg);
                            stack_port.wdata = slot_addr;
                            depth_next       = CNT_W'(depth_reg + 1'b1);
                            live_next        = live_dn;
                            res.done         = 1'b1;
                        end
                    end
                    else if (req_reg.func == FUNC_SET)
                    begin
                        if (in_range && (flag_rdata != req_reg.want))
                        begin
                            flag_port.we    = 1'b1;
                            flag_port.waddr = slot_addr;
                            flag_port.wdata = req_reg.want;
                            live_next       = req_reg.want ? live_up : live_dn;
                            res.done        = 1'b1;
                        end
                    end
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    commit          = 1'b1;
                    flag_port.we    = 1'b1;
                    flag_port.waddr = got_reg;
                    flag_port.wdata = 1'b1;
                    depth_next      = CNT_W'(depth_reg - 1'b1);
                    live_next       = flag_rdata ? live_reg : live_up;
                    res.slot        = SLOT_W'(got_reg);
                    res.done        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        res.live = live_next;

        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            fresh_reg     <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            fresh_reg     <= fresh_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_req;
        end
        got_reg <= got_next;
        if (commit)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

>>> rtl/slot_allocator_lifo_free_list_top.sv
// ----------------------------------------------------------------------------
// slot_allocator_lifo_free_list_top
// Slot allocator with a LIFO free list, flag and stack held in memories.
// ----------------------------------------------------------------------------
// One item at a time. Free, set-activity, a fresh allocate and a failed
// allocate are decided in the look state after acceptance; an allocate served
// from the free stack also passes the pop state, since the popped slot's flag
// read follows the stack read in the registered-read memories. The result sits
// in an output register, so the next item is taken while it waits. Flags need
// no clearing pass after reset: only slots below the fresh mark are ever looked
// up, and each was written when first handed out.
module slot_allocator_lifo_free_list_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [slafl_pkg::S_TDATA_W-1:0]     s_tdata,  // slot_index, make_active
    input  logic [slafl_pkg::S_TUSER_W-1:0]     s_tuser,  // func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [slafl_pkg::M_TDATA_W-1:0]     m_tdata,  // slot_out, live_count
    output logic [slafl_pkg::M_TUSER_W-1:0]     m_tuser   // done_res
);

    import slafl_pkg::*;

    req_t              in_req;
    res_t              out_res;
    flag_port_t        flag_port;
    stack_port_t       stack_port;
    logic              flag_rdata;
    logic [ADDR_W-1:0] stack_rdata;

    assign in_req.func = s_tuser[FUNC_W-1:0];
    assign in_req.slot = s_tdata[SLOT_W-1:0];
    assign in_req.want = s_tdata[SLOT_W];

    slafl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_req      (in_req),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (out_res),
        .flag_port   (flag_port),
        .flag_rdata  (flag_rdata),
        .stack_port  (stack_port),
        .stack_rdata (stack_rdata)
    );

    slafl_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_flag_ram (
        .clk   (clk),
        .we    (flag_port.we),
        .waddr (flag_port.waddr),
        .wdata (flag_port.wdata),
        .re    (flag_port.re),
        .raddr (flag_port.raddr),
        .rdata (flag_rdata)
    );

    slafl_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_port.we),
        .waddr (stack_port.waddr),
        .wdata (stack_port.wdata),
        .re    (stack_port.re),
        .raddr (stack_port.raddr),
        .rdata (stack_rdata)
    );

    assign m_tdata = {3'b000, out_res.live, out_res.slot};
    assign m_tuser = out_res.done;

endmodule

>>> rtl/slafl_checker.sv
// ----------------------------------------------------------------------------
// slafl_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module slafl_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [slafl_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [slafl_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [slafl_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [slafl_pkg::M_TUSER_W-1:0] m_tuser
);

    import slafl_pkg::*;

    logic in_acc;

    assign in_acc = s_tvalid && s_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("input taken while an item is in flight");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_acc, 2) || $past(in_acc, 3))
        else $error("result without a matching item");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> int'(m_tdata[SLOT_W+LIVE_W-1:SLOT_W]) <= SLOTS)
        else $error("live count above pool size");

endmodule

bind slot_allocator_lifo_free_list_top slafl_checker u_slafl_checker (.*);

>>> tb/tb_slot_allocator_lifo_free_list_top.sv
// ----------------------------------------------------------------------------
// tb_slot_allocator_lifo_free_list_top
// Self-checking bench for the LIFO free-list slot allocator. A directed
// sequence covers the corner cases, then random phases drive the pool to
// exhaustion and release slots back onto the free stack. Each result is
// compared with a behavioral pool model kept in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_slot_allocator_lifo_free_list_top;

    timeunit 1ns;
    timeprecision 1ps;

    import slafl_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    class slot_pool_scoreboard;
        bit                flag_set [SLOTS];
        logic [SLOT_W-1:0] stack_slots [SLOTS];
        int unsigned       stack_top;
        int unsigned       fresh_mark;
        logic [LIVE_W-1:0] live_now;
        res_t              expected_q [$];
        int                errors;
        int                pool_full_hits;

        function new();
            foreach (flag_set[i]) flag_set[i] = 1'b0;
            stack_top       = 0;
            fresh_mark      = 0;
            live_now        = '0;
            errors          = 0;
            pool_full_hits  = 0;
        endfunction

        function void bump_live(bit up);
            if (up && live_now != LIVE_MAX)
                live_now = live_now + 1'b1;
            else if (!up && live_now != '0)
                live_now = live_now - 1'b1;
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot,
                                   logic want);
            res_t        exp_res;
            int unsigned got;
            bit          ok;
            bit          in_range;
            in_range      = slot < fresh_mark;
            exp_res.slot  = slot;
            exp_res.done  = 1'b0;
            ok            = 1'b0;
            got           = 0;
            case (func)
                FUNC_ALLOC:
                begin
                    if (stack_top > 0) begin
                        stack_top = stack_top - 1;
                        got       = 32'(stack_slots[stack_top]);
                        ok        = 1'b1;
                    end
                    else if (fresh_mark < SLOTS) begin
                        got        = fresh_mark;
                        fresh_mark = fresh_mark + 1;
                        ok         = 1'b1;
                    end
                    if (ok) begin
                        if (!flag_set[got]) begin
                            flag_set[got] = 1'b1;
                            bump_live(1'b1);
                        end
                        exp_res.slot = got[SLOT_W-1:0];
                        exp_res.done = 1'b1;
                    end
                    else begin
                        exp_res.slot = '0;
                        pool_full_hits++;
                    end
                end
                FUNC_FREE:
                begin
                    if (in_range && flag_set[slot] && stack_top < SLOTS) begin
                        flag_set[slot]         = 1'b0;
                        stack_slots[stack_top] = slot;
                        stack_top              = stack_top + 1;
                        bump_live(1'b0);
                        exp_res.done = 1'b1;
                    end
                end
                FUNC_SET:
                begin
                    if (in_range && flag_set[slot] != want) begin
                        flag_set[slot] = want;
                        bump_live(want);
                        exp_res.done = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            exp_res.live = live_now;
            expected_q = {expected_q, exp_res};
        endfunction

        function void check_result(res_t got);
            res_t exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result slot=%0d done=%0d live=%0d",
                         $time, got.slot, got.done, got.live);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.slot !== exp_res.slot) begin
                $display("%0t: slot_out expected %0d actual %0d",
                         $time, exp_res.slot, got.slot);
                errors++;
            end
            if (got.done !== exp_res.done) begin
                $display("%0t: done_res expected %0d actual %0d",
                         $time, exp_res.done, got.done);
                errors++;
            end
            if (got.live !== exp_res.live) begin
                $display("%0t: live_count expected %0d actual %0d",
                         $time, exp_res.live, got.live);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int pick_active();
            int start;
            int idx;
            if (fresh_mark == 0)
                return $urandom_range(SLOTS - 1);
            start = $urandom_range(fresh_mark - 1);
            for (int i = 0; i < fresh_mark; i++) begin
                idx = (start + i) % fresh_mark;
                if (flag_set[idx])
                    return idx;
            end
            return start;
        endfunction

        function int pick_issued();
            if (fresh_mark == 0)
                return 0;
            return $urandom_range(fresh_mark - 1);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    slot_pool_scoreboard sb = new();

    int snd_idle_pct = 25;
    int rcv_idle_pct = 66;
    int hold_trigger = 0;

    slot_allocator_lifo_free_list_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = 80;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.slot = m_tdata[SLOT_W-1:0];
            got.live = m_tdata[SLOT_W +: LIVE_W];
            got.done = m_tuser[0];
            sb.check_result(got);
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot,
                             input logic want);
        int gaps;
        gaps = 0;
        while (gaps < 8 && $urandom_range(99) < snd_idle_pct)
            gaps++;
        if (gaps > 0) begin
            s_tvalid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-SLOT_W-1){1'b0}}, want, slot};
        s_tuser  <= func;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(func, slot, want);
    endtask

    task automatic random_item(input int alloc_pct, input int free_pct, input int set_pct);
        int r;
        r = $urandom_range(99);
        if (r < alloc_pct)
            send_item(FUNC_ALLOC, SLOT_W'($urandom_range(SLOTS - 1)), 1'($urandom_range(1)));
        else if (r < alloc_pct + free_pct)
            send_item(FUNC_FREE, SLOT_W'(sb.pick_active()), 1'($urandom_range(1)));
        else if (r < alloc_pct + free_pct + set_pct)
            send_item(FUNC_SET, SLOT_W'(sb.pick_issued()), 1'($urandom_range(1)));
        else
            send_item(FUNC_W'($urandom_range(3)), SLOT_W'($urandom_range(SLOTS - 1)),
                      1'($urandom_range(1)));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle_pct = 25;
        rcv_idle_pct = 66;
        send_item(FUNC_ALLOC, 10'd0,    1'b0);
        send_item(FUNC_ALLOC, 10'd1023, 1'b1);
        send_item(FUNC_ALLOC, 10'd0,    1'b0);
        send_item(FUNC_FREE,  10'd1023, 1'b0);   // never issued
        send_item(FUNC_SET,   10'd1023, 1'b1);   // never issued
        send_item(FUNC_FREE,  10'd1,    1'b0);
        send_item(FUNC_FREE,  10'd1,    1'b1);   // already inactive
        send_item(FUNC_SET,   10'd2,    1'b1);   // no change
        send_item(FUNC_SET,   10'd0,    1'b0);
        send_item(FUNC_SET,   10'd0,    1'b0);   // no change
        send_item(FUNC_SET,   10'd1,    1'b1);   // stacked slot made active
        send_item(FUNC_ALLOC, 10'd0,    1'b0);   // pops an active slot
        send_item(FUNC_NONE,  10'd1023, 1'b1);
        send_item(FUNC_NONE,  10'd0,    1'b0);
        send_item(FUNC_FREE,  10'd0,    1'b0);
        send_item(FUNC_SET,   10'd0,    1'b1);
        send_item(FUNC_FREE,  10'd0,    1'b1);
        send_item(FUNC_FREE,  10'd2,    1'b0);
        send_item(FUNC_ALLOC, 10'd512,  1'b0);
        send_item(FUNC_ALLOC, 10'd341,  1'b1);
        send_item(FUNC_ALLOC, 10'd682,  1'b0);
        send_item(FUNC_ALLOC, 10'd1023, 1'b1);

        repeat (30) random_item(35, 30, 25);
        drain();

        // fill the pool until allocations fail
        snd_idle_pct = 66;
        rcv_idle_pct = 25;
        n = 0;
        while (sb.pool_full_hits < 4 && n < 1400) begin
            random_item(90, 4, 3);
            n++;
        end
        drain();

        // release slots at full rate, then hold off the receiver
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        repeat (80) random_item(3, 85, 9);

        hold_trigger = hold_trigger + 1;
        repeat (40) random_item(35, 30, 25);
        drain();

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
rtl/slafl_pkg.sv
rtl/slafl_ram.sv
rtl/slafl_ctrl.sv
rtl/slot_allocator_lifo_free_list_top.sv
rtl/slafl_checker.sv
tb/tb_slot_allocator_lifo_free_list_top.sv
